/* design/assert_macros.svh */
// Assertion helpers shared by the list design.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge.
`define BPL_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication.
`define BPL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bpl_pkg.sv */
// ---------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants of the bounded positional list: command and
// status codes, item structs and storage sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpl_pkg;

    // Storage size
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // Output queue between the list engine and the result port
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int LVL_W    = $clog2(OQ_DEPTH + 1);
    localparam logic [LVL_W-1:0] OQ_FULL = LVL_W'(OQ_DEPTH);

    // Command codes
    localparam logic [2:0] CMD_INSERT_AT   = 3'd0;
    localparam logic [2:0] CMD_DELETE_AT   = 3'd1;
    localparam logic [2:0] CMD_DELETE_HEAD = 3'd2;
    localparam logic [2:0] CMD_DELETE_TAIL = 3'd3;
    localparam logic [2:0] CMD_READ_FWD    = 3'd4;
    localparam logic [2:0] CMD_READ_REV    = 3'd5;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] item_value;
        logic [5:0]         position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic [5:0]         entry_position;
        logic               last;
        logic [6:0]         entry_count;
    } out_item_t;

    // Result handed from the engine to the output queue
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_push_t;

endpackage

/* design/bpl_core.sv */
// ---------------------------------------------------------------------------
// bpl_core
// List engine: holds the entries in a one-port-read, one-port-write memory
// and moves them one step a cycle to open or close a gap, or streams them
// out for a read command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpl_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  bpl_pkg::in_item_t              cmd_data,
    input  logic [bpl_pkg::LVL_W-1:0]      oq_level,
    output bpl_pkg::res_push_t             push
);

    localparam int AW = bpl_pkg::ADDR_W;
    localparam int CW = bpl_pkg::COUNT_W;
    localparam int LW = bpl_pkg::LVL_W;

    typedef enum logic [2:0] {
        IDLE,
        SHIFT_UP,
        PUT,
        SHIFT_DOWN,
        DRAIN,
        READ,
        RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      stop_reg, stop_next;
    logic [AW-1:0]      put_reg, put_next;
    logic signed [31:0] val_reg, val_next;
    logic               rev_reg, rev_next;
    logic [1:0]         status_reg, status_next;
    logic               pend_reg, pend_next;
    logic               pend_rd_reg, pend_rd_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               pend_last_reg, pend_last_next;

    // Entry memory
    logic signed [31:0] mem [bpl_pkg::DEPTH];
    logic signed [31:0] rdata_reg;
    logic               mem_re, mem_we;
    logic [AW-1:0]      mem_raddr, mem_waddr;
    logic signed [31:0] mem_wdata;

    logic [7:0]         pos8, cnt8, del8;
    logic               read_push;
    logic [LW:0]        occ;
    logic               room;

    assign cmd_ready = (state_reg == IDLE);
    assign pos8      = 8'(cmd_data.position);
    assign cnt8      = 8'(count_reg);
    assign del8      = (cmd_data.cmd == bpl_pkg::CMD_DELETE_HEAD) ? 8'd0 : pos8;

    // Reserve a queue slot for every read in flight
    assign read_push = pend_reg && pend_rd_reg;
    assign occ       = {1'b0, oq_level} + {{LW{1'b0}}, read_push};
    assign room      = (occ < (LW+1)'(bpl_pkg::OQ_DEPTH));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        stop_next      = stop_reg;
        put_next       = put_reg;
        val_next       = val_reg;
        rev_next       = rev_reg;
        status_next    = status_reg;
        pend_next      = 1'b0;
        pend_rd_next   = 1'b0;
        pend_addr_next = cur_reg;
        pend_last_next = (cur_reg == stop_reg);
        mem_re         = 1'b0;
        mem_raddr      = cur_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = rdata_reg;
        push           = '0;

        // Write back a shifted entry in the cycle after its read
        if (pend_reg && !pend_rd_reg) begin
            mem_we = 1'b1;
            if (state_reg == SHIFT_UP || state_reg == PUT) begin
                mem_waddr = pend_addr_reg + 1'b1;
            end else begin
                mem_waddr = pend_addr_reg - 1'b1;
            end
        end

        // Forward a read entry to the output queue
        if (read_push) begin
            push.valid               = 1'b1;
            push.item.status         = bpl_pkg::STAT_OK;
            push.item.entry_value    = rdata_reg;
            push.item.entry_position = 6'(pend_addr_reg);
            push.item.last           = pend_last_reg;
            push.item.entry_count    = 7'(count_reg);
        end

        case (state_reg)
            IDLE: begin
                if (cmd_valid) begin
                    status_next = bpl_pkg::STAT_OK;
                    state_next  = RESULT;
                    case (cmd_data.cmd)
                        bpl_pkg::CMD_INSERT_AT: begin
                            if (cnt8 >= 8'(bpl_pkg::DEPTH)) begin
                                status_next = bpl_pkg::STAT_FULL;
                            end else begin
                                val_next   = cmd_data.item_value;
                                count_next = count_reg + 1'b1;
                                if (pos8 < cnt8) begin
                                    put_next   = AW'(pos8);
                                    cur_next   = AW'(cnt8 - 8'd1);
                                    stop_next  = AW'(pos8);
                                    state_next = SHIFT_UP;
                                end else begin
                                    put_next   = AW'(cnt8);
                                    state_next = PUT;
                                end
                            end
                        end
                        bpl_pkg::CMD_DELETE_AT, bpl_pkg::CMD_DELETE_HEAD: begin
                            if (count_reg == '0) begin
                                status_next = bpl_pkg::STAT_EMPTY;
                            end else if (del8 >= cnt8) begin
                                status_next = bpl_pkg::STAT_RANGE;
                            end else begin
                                count_next = count_reg - 1'b1;
                                if (del8 + 8'd1 < cnt8) begin
                                    cur_next   = AW'(del8 + 8'd1);
                                    stop_next  = AW'(cnt8 - 8'd1);
                                    state_next = SHIFT_DOWN;
                                end
                            end
                        end
                        bpl_pkg::CMD_DELETE_TAIL: begin
                            if (count_reg == '0) begin
                                status_next = bpl_pkg::STAT_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bpl_pkg::CMD_READ_FWD, bpl_pkg::CMD_READ_REV: begin
                            if (count_reg == '0) begin
                                status_next = bpl_pkg::STAT_EMPTY;
                            end else begin
                                rev_next   = (cmd_data.cmd == bpl_pkg::CMD_READ_REV);
                                if (cmd_data.cmd == bpl_pkg::CMD_READ_REV) begin
                                    cur_next  = AW'(cnt8 - 8'd1);
                                    stop_next = '0;
                                end else begin
                                    cur_next  = '0;
                                    stop_next = AW'(cnt8 - 8'd1);
                                end
                                state_next = READ;
                            end
                        end
                        default: begin
                            status_next = bpl_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            // Move entries one place toward the tail, highest first
            SHIFT_UP: begin
                mem_re    = 1'b1;
                pend_next = 1'b1;
                if (cur_reg == stop_reg) begin
                    state_next = PUT;
                end else begin
                    cur_next = cur_reg - 1'b1;
                end
            end
            // Drop the new value into the gap once the last move lands
            PUT: begin
                if (!pend_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = put_reg;
                    mem_wdata  = val_reg;
                    state_next = RESULT;
                end
            end
            // Move entries one place toward the head, lowest first
            SHIFT_DOWN: begin
                mem_re    = 1'b1;
                pend_next = 1'b1;
                if (cur_reg == stop_reg) begin
                    state_next = DRAIN;
                end else begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            DRAIN: begin
                if (!pend_reg) begin
                    state_next = RESULT;
                end
            end
            // Stream entries while the output queue has room
            READ: begin
                if (room) begin
                    mem_re       = 1'b1;
                    pend_next    = 1'b1;
                    pend_rd_next = 1'b1;
                    if (cur_reg == stop_reg) begin
                        state_next = IDLE;
                    end else if (rev_reg) begin
                        cur_next = cur_reg - 1'b1;
                    end else begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end
            // Report status and count for a non-read command or a read of an empty list
            RESULT: begin
                if (oq_level < bpl_pkg::OQ_FULL) begin
                    push.valid               = 1'b1;
                    push.item.status         = status_reg;
                    push.item.entry_value    = '0;
                    push.item.entry_position = '0;
                    push.item.last           = 1'b1;
                    push.item.entry_count    = 7'(count_reg);
                    state_next               = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold control state and command context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            pend_rd_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            pend_rd_reg <= pend_rd_next;
        end
        cur_reg       <= cur_next;
        stop_reg      <= stop_next;
        put_reg       <= put_next;
        val_reg       <= val_next;
        rev_reg       <= rev_next;
        status_reg    <= status_next;
        pend_addr_reg <= pend_addr_next;
        pend_last_reg <= pend_last_next;
    end

    // Entry memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    `BPL_ASSERT(a_count_max, aclk, aresetn, count_reg <= CW'(bpl_pkg::DEPTH), "count above depth")
    `BPL_ASSERT_IMP(a_push_room, aclk, aresetn, push.valid, oq_level < bpl_pkg::OQ_FULL, "push into full queue")
    `BPL_ASSERT_IMP(a_write_state, aclk, aresetn, mem_we, (state_reg != IDLE) && (state_reg != READ) && (state_reg != RESULT), "memory write outside shift")
    `BPL_ASSERT_NEXT(a_full_insert, aclk, aresetn, cmd_valid && cmd_ready && (cmd_data.cmd == bpl_pkg::CMD_INSERT_AT) && (count_reg == CW'(bpl_pkg::DEPTH)), $stable(count_reg), "full insert changed count")

endmodule

/* design/bounded_positional_list.sv */
// ---------------------------------------------------------------------------
// bounded_positional_list
// Ordered list of up to DEPTH signed 32-bit values with positional insert
// and delete, head/tail delete, and forward or reverse read-out.
// ---------------------------------------------------------------------------
//
//  port group   dir  struct       moves
//  s_*          in   in_item_t    one command item
//  m_*          out  out_item_t   one result item (reads: one per entry)
//
//  Flow: a command is taken only while the engine is idle. An insert below
//  count moves the entries from the tail down to the position one place
//  toward the tail, then writes the value; a delete below count-1 moves the
//  later entries one place toward the head; a read streams the entries via
//  the single memory read port, one entry a cycle while the queue has room.
//  Reset: aresetn clears count and control; the entry memory is not cleared.
//  Stalls: results wait in a 4-item output queue; reads pause while full.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_positional_list (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bpl_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bpl_pkg::out_item_t   m_data
);

    localparam int QAW = bpl_pkg::OQ_AW;
    localparam int LW  = bpl_pkg::LVL_W;

    bpl_pkg::res_push_t  push;
    bpl_pkg::out_item_t  oq_mem [bpl_pkg::OQ_DEPTH];
    logic [QAW-1:0]      wptr_reg, rptr_reg;
    logic [LW-1:0]       level_reg, level_next;
    logic                pop;

    bpl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd_data  (s_data),
        .oq_level  (level_reg),
        .push      (push)
    );

    // Output queue
    assign m_valid = (level_reg != '0);
    assign m_data  = oq_mem[rptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        level_next = level_reg;
        if (push.valid && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push.valid && pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    // Advance pointers and level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            level_reg <= level_next;
            if (push.valid) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            oq_mem[wptr_reg] <= push.item;
        end
    end

    `BPL_ASSERT(a_level_max, aclk, aresetn, level_reg <= bpl_pkg::OQ_FULL, "queue level overflow")
    `BPL_ASSERT_NEXT(a_level_pop, aclk, aresetn, pop && !push.valid, level_reg == ($past(level_reg) - 1'b1), "pop did not lower level")
    `BPL_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled item changed")

endmodule
